### src/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants for the postfix expression evaluator: symbol
// codes, result select codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_STAR  = 8'h2A;
	localparam logic [7:0] SYM_SLASH = 8'h2F;

	// Source of the value written back over the first operand, one below the stack top.
	localparam logic [1:0] RES_ALU  = 2'd0;
	localparam logic [1:0] RES_MD   = 2'd1;
	localparam logic [1:0] RES_ZERO = 2'd2;

	typedef struct packed {
		logic       load;
		logic       push;
		logic       set_over;
		logic       set_under;
		logic       combine;
		logic [1:0] res_sel;
		logic       md_start;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic digit;
		logic muldiv;
		logic div_zero;
		logic full;
		logic short;
		logic md_done;
		logic last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### src/pee_muldiv.sv
// ----------------------------------------------------------------------------
// pee_muldiv
// Shared radix-2 multiply and divide unit. Multiplication is shift and add,
// division is restoring on magnitudes with the sign fixed afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_muldiv #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   is_div,
	input  wire logic [VALUE_WIDTH-1:0] a,
	input  wire logic [VALUE_WIDTH-1:0] b,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      result
);

	localparam int W    = VALUE_WIDTH;
	localparam int CNTW = $clog2(W);

	logic            busy_q;
	logic            done_q;
	logic            div_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    acc_q;
	logic [W-1:0]    mcand_q;
	logic [W-1:0]    mplier_q;
	logic [W-1:0]    rem_q;
	logic [W:0]      shifted;
	logic [W:0]      trial;
	logic [W-1:0]    mag_a;
	logic [W-1:0]    mag_b;

	assign mag_a   = a[W-1] ? (W'(0) - a) : a;
	assign mag_b   = b[W-1] ? (W'(0) - b) : b;
	assign shifted = {rem_q, mplier_q[W-1]};
	assign trial   = shifted - {1'b0, mcand_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[W-1] ^ b[W-1];
			cnt_q <= CNTW'(W - 1);
			acc_q <= '0;
			rem_q <= '0;
			if (is_div) begin
				mplier_q <= mag_a;
				mcand_q  <= mag_b;
			end else begin
				mplier_q <= b;
				mcand_q  <= a;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (div_q) begin
				// The dividend shifts out at the top while quotient bits enter below.
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
				end else begin
					rem_q <= shifted[W-1:0];
				end
				mplier_q <= {mplier_q[W-2:0], ~trial[W]};
			end else begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[W-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? (neg_q ? (W'(0) - mplier_q) : mplier_q) : acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiply/divide started while busy");

endmodule

`default_nettype wire

### src/pee_dpath.sv
// ----------------------------------------------------------------------------
// pee_dpath
// Evaluator datapath: operand stack memory, stack count, sticky flags, the
// add/subtract unit, the shared multiply/divide unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_dpath #(
	parameter int STACK_DEPTH = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   symbol,
	input  wire logic         last,
	input  wire pee_pkg::cmd_t cmd,
	output pee_pkg::stat_t    stat,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic signed [31:0] value,
	output logic [7:0]        final_depth,
	output logic              divide_by_zero,
	output logic              stack_underflow,
	output logic              stack_overflow
);

	localparam int W  = VALUE_WIDTH;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [7:0]    symbol_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic          divz_q;
	logic          under_q;
	logic          over_q;
	logic [W-1:0]  mem [STACK_DEPTH];
	logic [W-1:0]  rd_a_q;
	logic [W-1:0]  rd_b_q;
	logic          out_valid_q;
	logic [31:0]   value_q;
	logic [7:0]    depth_q;
	logic          divz_out_q;
	logic          under_out_q;
	logic          over_out_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [W-1:0]  wr_data;
	logic [W-1:0]  alu_res;
	logic [W-1:0]  md_res;
	logic          md_done;
	logic          is_div;
	logic          empty;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign is_div = (symbol_q == pee_pkg::SYM_SLASH);
	assign empty  = (count_q == '0);

	always_comb begin
		case (symbol_q)
			pee_pkg::SYM_PLUS:  alu_res = rd_a_q + rd_b_q;
			pee_pkg::SYM_MINUS: alu_res = rd_a_q - rd_b_q;
			default:            alu_res = '0;
		endcase
	end

	always_comb begin
		wr_en   = cmd.push | cmd.combine;
		wr_addr = cmd.push ? count_q[AW-1:0] : cnt_m2[AW-1:0];
		if (cmd.push) begin
			// Digits 0 to 9 are the low nibble of their ASCII codes.
			wr_data = W'(symbol_q[3:0]);
		end else begin
			case (cmd.res_sel)
				pee_pkg::RES_ALU: wr_data = alu_res;
				pee_pkg::RES_MD:  wr_data = md_res;
				default:          wr_data = '0;
			endcase
		end
	end

	// The two top entries are registered from the memory every cycle, so they
	// follow any write or count change once it has reached the memory and count.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_b_q <= mem[cnt_m1[AW-1:0]];
		rd_a_q <= mem[cnt_m2[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			symbol_q <= symbol;
			last_q   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			divz_q  <= 1'b0;
			under_q <= 1'b0;
			over_q  <= 1'b0;
		end else if (cmd.emit) begin
			count_q <= '0;
			divz_q  <= 1'b0;
			under_q <= 1'b0;
			over_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.combine) begin
				count_q <= cnt_m1;
			end
			if (cmd.set_over) begin
				over_q <= 1'b1;
			end
			if (cmd.set_under) begin
				under_q <= 1'b1;
			end
			if (cmd.combine && cmd.res_sel == pee_pkg::RES_ZERO) begin
				divz_q <= 1'b1;
			end
		end
	end

	pee_muldiv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.md_start),
		.is_div (is_div),
		.a      (rd_a_q),
		.b      (rd_b_q),
		.done   (md_done),
		.result (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q     <= empty ? 32'd0 : 32'(signed'(rd_b_q));
			depth_q     <= 8'(count_q);
			divz_out_q  <= divz_q;
			under_out_q <= under_q | empty;
			over_out_q  <= over_q;
		end
	end

	always_comb begin
		stat.digit    = symbol_q inside {[pee_pkg::SYM_ZERO:pee_pkg::SYM_NINE]};
		stat.muldiv   = (symbol_q == pee_pkg::SYM_STAR) || is_div;
		stat.div_zero = is_div && (rd_b_q == '0);
		stat.full     = (count_q == CW'(STACK_DEPTH));
		stat.short    = (count_q < CW'(2));
		stat.md_done  = md_done;
		stat.last     = last_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid       = out_valid_q;
	assign value           = signed'(value_q);
	assign final_depth     = depth_q;
	assign divide_by_zero  = divz_out_q;
	assign stack_underflow = under_out_q;
	assign stack_overflow  = over_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (count_q == '0) && !divz_q && !under_q && !over_q)
		else $error("stack or flags not cleared after result");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

endmodule

`default_nettype wire

### src/pee_ctrl.sv
// ----------------------------------------------------------------------------
// pee_ctrl
// Evaluator controller: accepts one symbol, sequences push, combine or
// multiply/divide, and on the final symbol loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pee_pkg::stat_t stat,
	output pee_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_WAIT   = 3'd2;
	localparam logic [2:0] ST_TOP    = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] after_op;

	assign in_ready = (state_q == ST_IDLE);
	assign after_op = stat.last ? ST_TOP : ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = after_op;
				if (stat.digit) begin
					if (stat.full) begin
						cmd.set_over = 1'b1;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (stat.short) begin
					cmd.set_under = 1'b1;
				end else if (stat.div_zero) begin
					cmd.combine = 1'b1;
					cmd.res_sel = pee_pkg::RES_ZERO;
				end else if (stat.muldiv) begin
					cmd.md_start = 1'b1;
					state_d      = ST_WAIT;
				end else begin
					cmd.combine = 1'b1;
					cmd.res_sel = pee_pkg::RES_ALU;
				end
			end
			ST_WAIT: begin
				if (stat.md_done) begin
					cmd.combine = 1'b1;
					cmd.res_sel = pee_pkg::RES_MD;
					state_d     = after_op;
				end
			end
			ST_TOP: begin
				// Wait state for the registered stack top read to catch up with the last write.
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.md_done |-> state_q == ST_WAIT)
		else $error("multiply/divide finished outside wait state");

endmodule

`default_nettype wire

### src/postfix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix expression evaluator: digits push, operators combine the two top
// stack entries, and the final symbol returns the top value, depth and flags.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Beat contents
//  in       in_valid/in_ready   symbol, last
//  out      out_valid/out_ready value, final_depth, divide_by_zero,
//                               stack_underflow, stack_overflow
//
// A digit, an add, a subtract or a divide by zero is taken in ST_IDLE and done
// in ST_DECODE. Multiply and divide also wait in ST_WAIT on the shared radix-2
// multiply/divide unit, which retires one bit per cycle.
// A final symbol reads the stack top in ST_TOP and loads the result in ST_EMIT.
// Reset empties the stack and clears the flags; stack contents are not reset.
// A result waiting on out_ready holds only a following final symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    symbol,
	input  wire logic          last,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic signed [31:0] value,
	output logic [7:0]         final_depth,
	output logic               divide_by_zero,
	output logic               stack_underflow,
	output logic               stack_overflow
);

	pee_pkg::cmd_t  cmd;
	pee_pkg::stat_t stat;

	pee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pee_dpath #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.symbol          (symbol),
		.last            (last),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.value           (value),
		.final_depth     (final_depth),
		.divide_by_zero  (divide_by_zero),
		.stack_underflow (stack_underflow),
		.stack_overflow  (stack_overflow)
	);

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the postfix expression evaluator core. A short table of
// directed expressions is followed by random postfix expressions, mostly
// well formed, with deep stacks and noise mixed in. A behavioral evaluator
// predicts every result beat, and the result channel is checked field by
// field while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int STK_DEPTH    = 128;
	localparam int RANDOM_ITEMS = 1530;
	localparam int DRAIN_EVERY  = 500;
	localparam int TAIL_CYCLES  = 64;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  depth;
		logic        div_zero;
		logic        under;
		logic        over;
	} eval_result_t;

	typedef struct packed {
		logic [7:0]   sym;
		logic         lst;
		int           rep;
		logic         typed;
		eval_result_t res;
	} stim_row_t;

	localparam eval_result_t NO_RES = '0;
	localparam int N_ROWS = 26;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         symbol;
	logic               last;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] value;
	logic [7:0]         final_depth;
	logic               divide_by_zero;
	logic               stack_underflow;
	logic               stack_overflow;

	postfix_expression_evaluator_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.symbol         (symbol),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.final_depth    (final_depth),
		.divide_by_zero (divide_by_zero),
		.stack_underflow(stack_underflow),
		.stack_overflow (stack_overflow)
	);

	// Directed expressions; a row with typed set carries its result by hand.
	stim_row_t expr_rows [N_ROWS] = '{
		'{pee_pkg::SYM_ZERO + 8'd5, 1'b1, 1,   1'b1, '{32'd5, 8'd1, 1'b0, 1'b0, 1'b0}},
		'{pee_pkg::SYM_PLUS,        1'b1, 1,   1'b1, '{32'd0, 8'd0, 1'b0, 1'b1, 1'b0}},
		'{pee_pkg::SYM_ZERO + 8'd7, 1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO,        1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_SLASH,       1'b1, 1,   1'b1, '{32'd0, 8'd1, 1'b1, 1'b0, 1'b0}},
		'{pee_pkg::SYM_ZERO + 8'd3, 1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_STAR,        1'b1, 1,   1'b1, '{32'd3, 8'd1, 1'b0, 1'b1, 1'b0}},
		'{pee_pkg::SYM_NINE,        1'b0, 128, 1'b0, NO_RES},
		'{pee_pkg::SYM_NINE,        1'b1, 1,   1'b1, '{32'd9, 8'd128, 1'b0, 1'b0, 1'b1}},
		'{pee_pkg::SYM_ZERO + 8'd8, 1'b0, 10,  1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO + 8'd2, 1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_STAR,        1'b0, 10,  1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO,        1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO + 8'd1, 1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_MINUS,       1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_SLASH, 1'b1, 1, 1'b1, '{32'h8000_0000, 8'd1, 1'b0, 1'b0, 1'b0}},
		'{pee_pkg::SYM_ZERO,        1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO + 8'd7, 1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_MINUS,       1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO + 8'd2, 1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_SLASH,       1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_NINE,        1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_PLUS,        1'b0, 1,   1'b0, NO_RES},
		'{pee_pkg::SYM_ZERO + 8'd4, 1'b0, 1,   1'b0, NO_RES},
		'{8'hFF,                    1'b1, 1,   1'b0, NO_RES},
		'{8'h00,                    1'b1, 1,   1'b1, '{32'd0, 8'd0, 1'b0, 1'b1, 1'b0}}
	};

	// Evaluator state.
	logic [31:0] opnd_stk [STK_DEPTH];
	int          stk_cnt = 0;
	logic        dz_flag = 1'b0;
	logic        under_flag = 1'b0;
	logic        over_flag = 1'b0;

	eval_result_t pending_results [$];
	eval_result_t want_res;
	int           errors = 0;
	int           items_sent = 0;
	int           burst_left = 0;
	int           cycle_count = 0;
	int           rx_mode = 0;
	int           rx_left = 0;
	int           rx_phase = 0;

	function automatic logic [31:0] combine(input logic [31:0] a, input logic [7:0] op,
		input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		case (op)
			pee_pkg::SYM_PLUS:  return a + b;
			pee_pkg::SYM_MINUS: return a - b;
			pee_pkg::SYM_STAR:  return a * b;
			pee_pkg::SYM_SLASH: begin
				if (b == 32'd0) begin
					dz_flag = 1'b1;
					return 32'd0;
				end
				ma = a[31] ? -a : a;
				mb = b[31] ? -b : b;
				q  = ma / mb;
				if (a[31] ^ b[31])
					q = -q;
				return q;
			end
			default:            return 32'd0;
		endcase
	endfunction

	// Applies one symbol; returns 1 with the result when the symbol closes an expression.
	function automatic bit eval_symbol(input logic [7:0] sym, input logic lst,
		output eval_result_t res);
		res = '0;
		if (sym inside {[pee_pkg::SYM_ZERO:pee_pkg::SYM_NINE]}) begin
			if (stk_cnt < STK_DEPTH) begin
				opnd_stk[stk_cnt] = 32'(sym - pee_pkg::SYM_ZERO);
				stk_cnt++;
			end else begin
				over_flag = 1'b1;
			end
		end else if (stk_cnt < 2) begin
			under_flag = 1'b1;
		end else begin
			opnd_stk[stk_cnt-2] = combine(opnd_stk[stk_cnt-2], sym, opnd_stk[stk_cnt-1]);
			stk_cnt--;
		end
		if (!lst)
			return 1'b0;
		if (stk_cnt == 0) begin
			under_flag = 1'b1;
			res.value = 32'd0;
		end else begin
			res.value = opnd_stk[stk_cnt-1];
		end
		res.depth    = 8'(stk_cnt);
		res.div_zero = dz_flag;
		res.under    = under_flag;
		res.over     = over_flag;
		stk_cnt    = 0;
		dz_flag    = 1'b0;
		under_flag = 1'b0;
		over_flag  = 1'b0;
		return 1'b1;
	endfunction

	// Offers one beat, waits for it to be taken, then updates the prediction.
	// Valid is left high afterwards; whoever spends time next lowers it.
	task automatic send_symbol(input logic [7:0] sym, input logic lst, input logic typed,
		input eval_result_t typed_res);
		int           gap;
		bit           taken;
		eval_result_t res;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		symbol   <= sym;
		last     <= lst;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		if (eval_symbol(sym, lst, res))
			pending_results.push_back(typed ? typed_res : res);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		return pee_pkg::SYM_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 11))
			0, 1, 2: return pee_pkg::SYM_PLUS;
			3, 4, 5: return pee_pkg::SYM_MINUS;
			6, 7:    return pee_pkg::SYM_STAR;
			8, 9, 10: return pee_pkg::SYM_SLASH;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One random expression: mostly well formed, a few near or past the stack depth,
	// and the rest noise that breaks the postfix order.
	task automatic run_expression();
		int         kind;
		int         pushes_left;
		int         ops_left;
		int         d;
		int         n;
		logic [7:0] s;
		kind = $urandom_range(0, 199);
		if (kind < 150) begin
			ops_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 6);
			pushes_left = ops_left + 1;
			d = 0;
			while (pushes_left + ops_left > 0) begin
				if (d >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 1) == 1)) begin
					s = pick_operator();
					ops_left--;
					d--;
				end else begin
					s = pick_digit();
					pushes_left--;
					d++;
				end
				send_symbol(s, (pushes_left + ops_left) == 0, 1'b0, NO_RES);
			end
		end else if (kind < 152) begin
			n = $urandom_range(124, 134);
			ops_left = $urandom_range(0, 4);
			for (int k = 0; k < n; k++)
				send_symbol(pick_digit(), (k == n - 1) && (ops_left == 0), 1'b0, NO_RES);
			for (int k = 0; k < ops_left; k++)
				send_symbol(pick_operator(), k == ops_left - 1, 1'b0, NO_RES);
		end else begin
			n = $urandom_range(1, 10);
			for (int k = 0; k < n; k++) begin
				s = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_digit();
				send_symbol(s, (k == n - 1) || ($urandom_range(0, 7) == 0), 1'b0, NO_RES);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("postfix_expression_evaluator_core regression: fail");
			$finish;
		end
	end

	// Receiver stall pattern: switches between always ready, coin flips,
	// mostly stalled and a fixed on/off rhythm.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (rx_phase % 8) < 3;
		endcase
	end

	// A result beat is taken at the next rising edge; sample it on the falling edge before.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: value %0d depth %0d",
					value, final_depth);
				errors++;
			end else begin
				want_res = pending_results.pop_front();
				if (value !== want_res.value) begin
					$error("value: expected %0d, actual %0d", $signed(want_res.value), value);
					errors++;
				end
				if (final_depth !== want_res.depth) begin
					$error("final_depth: expected %0d, actual %0d", want_res.depth, final_depth);
					errors++;
				end
				if (divide_by_zero !== want_res.div_zero) begin
					$error("divide_by_zero: expected %0b, actual %0b",
						want_res.div_zero, divide_by_zero);
					errors++;
				end
				if (stack_underflow !== want_res.under) begin
					$error("stack_underflow: expected %0b, actual %0b",
						want_res.under, stack_underflow);
					errors++;
				end
				if (stack_overflow !== want_res.over) begin
					$error("stack_overflow: expected %0b, actual %0b",
						want_res.over, stack_overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		int start_count;
		int next_drain;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		symbol   = 8'h00;
		last     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			for (int k = 0; k < expr_rows[r].rep; k++)
				send_symbol(expr_rows[r].sym, expr_rows[r].lst, expr_rows[r].typed,
					expr_rows[r].res);
		drain_results();

		start_count = items_sent;
		next_drain  = DRAIN_EVERY;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			run_expression();
			if (items_sent - start_count >= next_drain) begin
				drain_results();
				next_drain += DRAIN_EVERY;
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("postfix_expression_evaluator_core regression: pass");
		else
			$display("postfix_expression_evaluator_core regression: fail");
		$finish;
	end

endmodule
